>>> hw/rtl/eslp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eslp_pkg
// Shared types, constants and character tables of the event-stream parser.
// ----------------------------------------------------------------------------
package eslp_pkg;

  localparam int NAME_CHARS_DEF  = 31;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int OUT_LEN_W       = 16;
  localparam int MSG_LEN         = 7;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_EVENT = 2'd2
  } value_kind_t;

  typedef enum logic [1:0] {
    CMD_PAY  = 2'd0,
    CMD_NAME = 2'd1,
    CMD_DISP = 2'd2
  } cmd_kind_t;

  function automatic logic [7:0] data_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h64;
      3'd1:    ch = 8'h61;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h61;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] event_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h65;
      3'd1:    ch = 8'h76;
      3'd2:    ch = 8'h65;
      3'd3:    ch = 8'h6e;
      3'd4:    ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] msg_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h6d;
      3'd1:    ch = 8'h65;
      3'd2:    ch = 8'h73;
      3'd3:    ch = 8'h73;
      3'd4:    ch = 8'h61;
      3'd5:    ch = 8'h67;
      3'd6:    ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> hw/rtl/eslp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eslp_fifo
// Small command queue between the line parser front and the output back.
// ----------------------------------------------------------------------------
module eslp_fifo import eslp_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             q_full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             q_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNW-1:0]   cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign q_full  = (cnt_r == CNW'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : PW'(wp_r + 1'b1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : PW'(rp_r + 1'b1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = CNW'(cnt_r + 1'b1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = CNW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wdata;
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNW'(DEPTH)) else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !rd |=> q_full) else $error("queue lost an entry while full");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> (wp_r == rp_r)) else $error("empty queue with pointers apart");
`endif

endmodule

>>> hw/rtl/eslp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eslp_front
// Line parser: classifies each byte and issues payload, name-store and
// dispatch commands, at most one per byte.
// ----------------------------------------------------------------------------
module eslp_front import eslp_pkg::*; #(
  parameter int NAME_CHARS  = NAME_CHARS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                acc,
  input  logic [7:0]                                          byte_in,
  output logic                                                cmd_vld,
  output logic [2+8+$clog2(NAME_CHARS+1)+LENGTH_BITS-1:0]     cmd_data
);

  localparam int NLW = $clog2(NAME_CHARS + 1);

  logic                   after_cr_r, after_cr_nxt;
  logic                   nonempty_r, nonempty_nxt;
  logic [2:0]             pos_r, pos_nxt;
  logic                   mism_r, mism_nxt;
  logic                   in_value_r, in_value_nxt;
  value_kind_t            kind_r, kind_nxt;
  logic                   skip_r, skip_nxt;
  logic                   have_r, have_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;
  logic [NLW-1:0]         len_r, len_nxt;

  value_kind_t      res_kind;
  cmd_kind_t        c_kind;
  logic [7:0]       c_byte;
  logic [NLW-1:0]   c_aux;
  logic             count_up;

  always_comb begin
    res_kind = KIND_NONE;
    if (!mism_r) begin
      if (kind_r == KIND_DATA && pos_r == 3'd4) begin
        res_kind = KIND_DATA;
      end else if (kind_r == KIND_EVENT && pos_r == 3'd5) begin
        res_kind = KIND_EVENT;
      end
    end
  end

  always_comb begin
    after_cr_nxt = after_cr_r;
    nonempty_nxt = nonempty_r;
    pos_nxt      = pos_r;
    mism_nxt     = mism_r;
    in_value_nxt = in_value_r;
    kind_nxt     = kind_r;
    skip_nxt     = skip_r;
    have_nxt     = have_r;
    len_nxt      = len_r;
    cmd_vld      = 1'b0;
    c_kind       = CMD_PAY;
    c_byte       = byte_in;
    c_aux        = '0;
    count_up     = 1'b0;

    if (acc) begin
      if (byte_in == CH_CR || byte_in == CH_LF) begin
        if (byte_in == CH_LF && after_cr_r) begin
          after_cr_nxt = 1'b0;
        end else begin
          after_cr_nxt = (byte_in == CH_CR);
          if (!nonempty_r) begin
            if (have_r) begin
              cmd_vld = 1'b1;
              c_kind  = CMD_DISP;
              c_aux   = len_r;
            end
            have_nxt = 1'b0;
            len_nxt  = '0;
          end else if (!in_value_r) begin
            if (res_kind == KIND_DATA) begin
              if (have_r) begin
                cmd_vld  = 1'b1;
                c_byte   = CH_LF;
                count_up = 1'b1;
              end
              have_nxt = 1'b1;
            end else if (res_kind == KIND_EVENT) begin
              len_nxt = '0;
            end
          end
          nonempty_nxt = 1'b0;
          pos_nxt      = '0;
          mism_nxt     = 1'b0;
          in_value_nxt = 1'b0;
          kind_nxt     = KIND_NONE;
          skip_nxt     = 1'b0;
        end
      end else begin
        after_cr_nxt = 1'b0;
        nonempty_nxt = 1'b1;
        if (in_value_r) begin
          skip_nxt = 1'b0;
          if (!(skip_r && byte_in == CH_SPACE)) begin
            if (kind_r == KIND_DATA) begin
              cmd_vld  = 1'b1;
              count_up = 1'b1;
            end else if (kind_r == KIND_EVENT && len_r < NLW'(NAME_CHARS)) begin
              cmd_vld = 1'b1;
              c_kind  = CMD_NAME;
              c_aux   = len_r;
              len_nxt = NLW'(len_r + 1'b1);
            end
          end
        end else if (byte_in == CH_COLON) begin
          in_value_nxt = 1'b1;
          kind_nxt     = res_kind;
          skip_nxt     = 1'b1;
          if (res_kind == KIND_DATA) begin
            if (have_r) begin
              cmd_vld  = 1'b1;
              c_byte   = CH_LF;
              count_up = 1'b1;
            end
            have_nxt = 1'b1;
          end else if (res_kind == KIND_EVENT) begin
            len_nxt = '0;
          end
        end else begin
          if (!mism_r) begin
            if (pos_r == 3'd0) begin
              if (byte_in == CH_D) begin
                kind_nxt = KIND_DATA;
              end else if (byte_in == CH_E) begin
                kind_nxt = KIND_EVENT;
              end else begin
                mism_nxt = 1'b1;
              end
            end else if (kind_r == KIND_DATA) begin
              if (pos_r >= 3'd4 || byte_in != data_char(pos_r)) begin
                mism_nxt = 1'b1;
              end
            end else if (kind_r == KIND_EVENT) begin
              if (pos_r >= 3'd5 || byte_in != event_char(pos_r)) begin
                mism_nxt = 1'b1;
              end
            end else begin
              mism_nxt = 1'b1;
            end
          end
          if (pos_r < 3'd7) begin
            pos_nxt = pos_r + 3'd1;
          end
        end
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc && !nonempty_r && !(byte_in == CH_LF && after_cr_r)
        && (byte_in == CH_CR || byte_in == CH_LF)) begin
      cnt_nxt = '0;
    end else if (count_up && cnt_r != '1) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign cmd_data = {c_kind, c_byte, c_aux, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_cr_r <= 1'b0;
      nonempty_r <= 1'b0;
      pos_r      <= '0;
      mism_r     <= 1'b0;
      in_value_r <= 1'b0;
      kind_r     <= KIND_NONE;
      skip_r     <= 1'b0;
      have_r     <= 1'b0;
      cnt_r      <= '0;
      len_r      <= '0;
    end else begin
      after_cr_r <= after_cr_nxt;
      nonempty_r <= nonempty_nxt;
      pos_r      <= pos_nxt;
      mism_r     <= mism_nxt;
      in_value_r <= in_value_nxt;
      kind_r     <= kind_nxt;
      skip_r     <= skip_nxt;
      have_r     <= have_nxt;
      cnt_r      <= cnt_nxt;
      len_r      <= len_nxt;
    end
  end

`ifndef SYNTH
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= NLW'(NAME_CHARS)) else $error("name length beyond store");
  a_skip_in_value: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> in_value_r) else $error("space skip outside a value");
  a_disp_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_vld && c_kind == CMD_DISP |=> !have_r && cnt_r == '0)
    else $error("dispatch did not clear the event");
`endif

endmodule

>>> hw/rtl/eslp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eslp_back
// Executes queued commands: forwards payload bytes, writes the name store
// and plays out dispatch runs into the output register.
// ----------------------------------------------------------------------------
module eslp_back import eslp_pkg::*; #(
  parameter int NAME_CHARS  = NAME_CHARS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic [2+8+$clog2(NAME_CHARS+1)+LENGTH_BITS-1:0] q_data,
  input  logic                                            q_empty,
  output logic                                            q_pop,
  output logic                                            out_empty,
  input  logic                                            out_pop,
  output logic                                            out_item_kind,
  output logic [7:0]                                      out_byte_out,
  output logic                                            out_run_last,
  output logic [OUT_LEN_W-1:0]                            out_payload_length
);

  localparam int NLW = $clog2(NAME_CHARS + 1);
  localparam int AW  = $clog2(NAME_CHARS);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RUN  = 2'b10
  } back_state_t;

  back_state_t            state_r, state_nxt;
  logic [NLW-1:0]         idx_r, idx_nxt, n_r, n_nxt;
  logic                   msg_r, msg_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;
  logic                   ov_r, ov_nxt;
  logic [7:0]             rd_r;
  logic [7:0]             mem [NAME_CHARS];

  cmd_kind_t              h_kind;
  logic [7:0]             h_byte;
  logic [NLW-1:0]         h_aux;
  logic [LENGTH_BITS-1:0] h_cnt;
  logic                   load_ok, load, we, last;
  logic                   ld_kind, ld_last;
  logic [7:0]             ld_byte;
  logic [OUT_LEN_W-1:0]   ld_len;
  logic [AW-1:0]          rd_addr;

  assign h_kind  = cmd_kind_t'(q_data[2+8+NLW+LENGTH_BITS-1 -: 2]);
  assign h_byte  = q_data[8+NLW+LENGTH_BITS-1 -: 8];
  assign h_aux   = q_data[NLW+LENGTH_BITS-1 -: NLW];
  assign h_cnt   = q_data[LENGTH_BITS-1:0];
  assign load_ok = !ov_r || out_pop;
  assign last    = (NLW'(idx_r + 1'b1) == n_r);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    msg_nxt   = msg_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    load      = 1'b0;
    we        = 1'b0;
    ld_kind   = 1'b0;
    ld_byte   = h_byte;
    ld_last   = 1'b0;
    ld_len    = '0;
    rd_addr   = '0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          case (h_kind)
            CMD_PAY: begin
              if (load_ok) begin
                load  = 1'b1;
                q_pop = 1'b1;
              end
            end
            CMD_NAME: begin
              we    = 1'b1;
              q_pop = 1'b1;
            end
            CMD_DISP: begin
              q_pop     = 1'b1;
              msg_nxt   = (h_aux == '0);
              n_nxt     = (h_aux == '0) ? NLW'(MSG_LEN) : h_aux;
              cnt_nxt   = h_cnt;
              idx_nxt   = '0;
              state_nxt = B_RUN;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      B_RUN: begin
        rd_addr = AW'(idx_r);
        if (load_ok) begin
          load    = 1'b1;
          ld_kind = 1'b1;
          ld_byte = msg_r ? msg_char(idx_r[2:0]) : rd_r;
          ld_last = last;
          ld_len  = last ? OUT_LEN_W'(cnt_r) : '0;
          idx_nxt = NLW'(idx_r + 1'b1);
          rd_addr = AW'(idx_r + 1'b1);
          if (last) begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_pop) begin
      ov_nxt = 1'b0;
    end
  end

  assign out_empty = !ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      idx_r   <= '0;
      n_r     <= '0;
      msg_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      n_r     <= n_nxt;
      msg_r   <= msg_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (load) begin
      out_item_kind      <= ld_kind;
      out_byte_out       <= ld_byte;
      out_run_last       <= ld_last;
      out_payload_length <= ld_len;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[AW'(h_aux)] <= h_byte;
    end
    rd_r <= mem[rd_addr];
  end

`ifndef SYNTH
  a_run_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_RUN |-> idx_r < n_r) else $error("run index past name length");
  a_run_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_RUN |-> !q_pop) else $error("queue popped during a run");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_RUN && load_ok && last |=> state_r == B_IDLE)
    else $error("run did not end on its last beat");
`endif

endmodule

>>> hw/rtl/event_stream_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_stream_line_parser
// Event-stream line parser: bytes in, payload bytes and dispatch name runs out.
// ----------------------------------------------------------------------------
// path: a payload byte passes through the command queue into the output register
// throughput: one byte per cycle while the command queue is not full; a dispatch
//   run enters B_RUN and then loads its name bytes (seven for the default name)
//   in order as the output drains, while the 4-entry command queue absorbs input
// reset: synchronous, active low; clears parser state, queue and output
//   valid flag; the name store holds no reset value and needs no clearing pass
module event_stream_line_parser import eslp_pkg::*; #(
  parameter int NAME_CHARS  = NAME_CHARS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           in_byte_in,
  output logic                 empty,
  input  logic                 pop,
  output logic                 out_item_kind,
  output logic [7:0]           out_byte_out,
  output logic                 out_run_last,
  output logic [OUT_LEN_W-1:0] out_payload_length
);

  localparam int CW = 2 + 8 + $clog2(NAME_CHARS + 1) + LENGTH_BITS;

  logic          acc, cmd_vld, q_empty, q_pop;
  logic [CW-1:0] cmd_data, q_data;

  assign acc = push && !full;

  eslp_front #(
    .NAME_CHARS  (NAME_CHARS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .byte_in  (in_byte_in),
    .cmd_vld  (cmd_vld),
    .cmd_data (cmd_data)
  );

  eslp_fifo #(
    .WIDTH (CW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (cmd_vld),
    .wdata   (cmd_data),
    .q_full  (full),
    .rd      (q_pop),
    .rdata   (q_data),
    .q_empty (q_empty)
  );

  eslp_back #(
    .NAME_CHARS  (NAME_CHARS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_data             (q_data),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_empty          (empty),
    .out_pop            (pop),
    .out_item_kind      (out_item_kind),
    .out_byte_out       (out_byte_out),
    .out_run_last       (out_run_last),
    .out_payload_length (out_payload_length)
  );

endmodule
